@@ rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the character stream tokenizer
// Holds the field widths, the scanner modes, the token kinds and the result
// item layout that the scanner, the result queue and the top level share.
// ----------------------------------------------------------------------------
package cst_pkg;

  // length saturation point and stream offset width
  localparam int LENGTH_LIMIT = 4095;
  localparam int OFFSET_BITS  = 24;

  localparam int KIND_W   = 3;
  localparam int START_W  = 24;
  localparam int LENGTH_W = 12;

  localparam logic [LENGTH_W-1:0] LEN_CAP =
    (LENGTH_LIMIT < 4095) ? LENGTH_W'(LENGTH_LIMIT) : LENGTH_W'(4095);

  // result queue depth, at least two so that one item's pair always fits
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_BANG       = 8'h21;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_STR   = 3'd3,
    MODE_REL   = 3'd4
  } scan_mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT = 3'd0,
    KIND_INT   = 3'd1,
    KIND_STR   = 3'd2,
    KIND_REL   = 3'd3,
    KIND_OTHER = 3'd4
  } token_kind_t;

  typedef struct packed {
    token_kind_t         kind;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } token_t;

  // what the scanner hands to the queue for one accepted item
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_out_t;

endpackage

@@ rtl/character_stream_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// character_stream_tokenizer_top: byte stream tokenizer
// Splits a byte stream into identifier, integer, string, relational-operator
// and single-character tokens, reporting kind, start offset and length.
// ----------------------------------------------------------------------------
// One byte item is taken per clock unless in_stall is high. The scanner
// state (mode, pending start and length, stream offset) updates at the edge
// that accepts the item, and the finished tokens it causes land in a
// four-entry result queue that feeds the output. A byte that closes a
// pending token and is itself a single-character token yields two result
// items, and the output moves one item per clock unless out_stall is high;
// the queue absorbs this and in_stall rises only when it has fewer than two
// free entries. With the output never stalled the queue never holds more
// than two items: a two-token byte leaves the scanner idle, and the next
// pending token has to be opened by a byte that yields nothing, so the input
// takes one byte per clock without a break. end_of_input items carry no
// byte, do not advance the offset and flush the pending token.
// ----------------------------------------------------------------------------
module character_stream_tokenizer_top (
  input  logic                           clk,
  input  logic                           rst,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     char_in,
  input  logic                           end_of_input,
  // token output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cst_pkg::KIND_W-1:0]     token_kind,
  output logic [cst_pkg::START_W-1:0]    token_start,
  output logic [cst_pkg::LENGTH_W-1:0]   token_length,
  output logic                           last_of_run
);

  logic                 in_accept;
  logic                 out_accept;
  logic                 room;
  cst_pkg::scan_out_t   scan_result;
  cst_pkg::token_t      head;

  // stall depends on queue fill only, never on in_valid
  assign in_stall   = !room;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // scanner: classifies the byte and updates the pending token
  cst_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .char_in      (char_in),
    .end_of_input (end_of_input),
    .result       (scan_result)
  );

  // result queue: decouples the two-token bytes from the output rate
  cst_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .data      (scan_result),
    .pop       (out_accept),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  // head entry drives the output fields directly
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

@@ rtl/cst_scan.sv @@
// ----------------------------------------------------------------------------
// cst_scan: scanner state and per-byte token logic
// Classifies one byte against the pending token and produces up to two
// finished tokens, compacted so the first valid one sits in the first slot.
// ----------------------------------------------------------------------------
module cst_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              char_in,
  input  logic                    end_of_input,
  output cst_pkg::scan_out_t      result
);

  cst_pkg::scan_mode_t                 mode, mode_next;
  logic [cst_pkg::START_W-1:0]         start, start_next;
  logic [cst_pkg::LENGTH_W-1:0]        length, length_next;
  logic [cst_pkg::OFFSET_BITS-1:0]     offset, offset_next;

  logic                                have_a, have_b, fresh;
  logic [cst_pkg::LENGTH_W-1:0]        grown, a_length;
  logic [cst_pkg::START_W-1:0]         pos;
  cst_pkg::token_t                     tok_a, tok_b;
  cst_pkg::token_kind_t                mode_kind;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[cst_pkg::CH_ZERO:cst_pkg::CH_NINE]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_rel(input logic [7:0] c);
    return c inside {cst_pkg::CH_LESS, cst_pkg::CH_GREATER, cst_pkg::CH_BANG,
                     cst_pkg::CH_EQUALS};
  endfunction

  always_comb begin
    case (mode)
      cst_pkg::MODE_IDENT: mode_kind = cst_pkg::KIND_IDENT;
      cst_pkg::MODE_INT:   mode_kind = cst_pkg::KIND_INT;
      cst_pkg::MODE_STR:   mode_kind = cst_pkg::KIND_STR;
      default:             mode_kind = cst_pkg::KIND_REL;
    endcase
  end

  assign grown = (length < cst_pkg::LEN_CAP) ? length + 1'b1 : length;
  assign pos   = cst_pkg::START_W'(offset);

  always_comb begin
    mode_next   = mode;
    start_next  = start;
    length_next = length;
    offset_next = offset;
    have_a      = 1'b0;
    have_b      = 1'b0;
    fresh       = 1'b0;
    a_length    = length;

    if (end_of_input) begin
      // flush whatever is pending, offset holds
      if (mode != cst_pkg::MODE_IDLE) begin
        have_a = 1'b1;
      end
      mode_next = cst_pkg::MODE_IDLE;
    end else begin
      if (offset != '1) begin
        offset_next = offset + 1'b1;
      end
      case (mode)
        cst_pkg::MODE_IDENT: begin
          if (is_alpha(char_in) || is_digit(char_in) || char_in == cst_pkg::CH_UNDERSCORE)
          begin
            length_next = grown;
          end else begin
            have_a = 1'b1;
            fresh  = 1'b1;
          end
        end
        cst_pkg::MODE_INT: begin
          if (is_digit(char_in)) begin
            length_next = grown;
          end else begin
            have_a = 1'b1;
            fresh  = 1'b1;
          end
        end
        cst_pkg::MODE_STR: begin
          length_next = grown;
          if (char_in == cst_pkg::CH_QUOTE) begin
            have_a    = 1'b1;
            a_length  = grown;
            mode_next = cst_pkg::MODE_IDLE;
          end
        end
        cst_pkg::MODE_REL: begin
          if (char_in == cst_pkg::CH_EQUALS) begin
            have_a      = 1'b1;
            a_length    = grown;
            length_next = grown;
            mode_next   = cst_pkg::MODE_IDLE;
          end else begin
            have_a = 1'b1;
            fresh  = 1'b1;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      if (fresh) begin
        mode_next = cst_pkg::MODE_IDLE;
        if (!is_space(char_in)) begin
          start_next  = pos;
          length_next = cst_pkg::LENGTH_W'(1);
          if (char_in == cst_pkg::CH_QUOTE) begin
            mode_next = cst_pkg::MODE_STR;
          end else if (is_digit(char_in)) begin
            mode_next = cst_pkg::MODE_INT;
          end else if (is_alpha(char_in) || char_in == cst_pkg::CH_UNDERSCORE) begin
            mode_next = cst_pkg::MODE_IDENT;
          end else if (is_rel(char_in)) begin
            mode_next = cst_pkg::MODE_REL;
          end else begin
            have_b = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    tok_a.kind   = mode_kind;
    tok_a.start  = start;
    tok_a.length = a_length;
    tok_a.last   = !have_b;
    tok_b.kind   = cst_pkg::KIND_OTHER;
    tok_b.start  = pos;
    tok_b.length = cst_pkg::LENGTH_W'(1);
    tok_b.last   = 1'b1;

    result.count  = {1'b0, have_a} + {1'b0, have_b};
    result.first  = have_a ? tok_a : tok_b;
    result.second = tok_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= cst_pkg::MODE_IDLE;
      start  <= '0;
      length <= '0;
      offset <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      start  <= start_next;
      length <= length_next;
      offset <= offset_next;
    end
  end

endmodule

@@ rtl/cst_outq.sv @@
// ----------------------------------------------------------------------------
// cst_outq: result queue
// Small circular queue of finished tokens; takes up to two per cycle and
// presents its oldest entry, one leaving per handshake.
// ----------------------------------------------------------------------------
module cst_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cst_pkg::scan_out_t   data,
  input  logic                 pop,
  output cst_pkg::token_t      head,
  output logic                 not_empty,
  output logic                 room
);

  cst_pkg::token_t                  slots [cst_pkg::QUEUE_DEPTH];
  logic [cst_pkg::QPTR_W-1:0]       rd_ptr, wr_ptr, wr_ptr_alt;
  logic [cst_pkg::QCNT_W-1:0]       count, count_next;
  logic [1:0]                       n_in;

  assign n_in       = push ? data.count : 2'd0;
  assign wr_ptr_alt = wr_ptr + 1'b1;
  assign count_next = count + cst_pkg::QCNT_W'(n_in) - cst_pkg::QCNT_W'(pop);

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  // two free slots guarantee any item's results fit
  assign room      = (count <= cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      slots[wr_ptr] <= data.first;
    end
    if (n_in == 2'd2) begin
      slots[wr_ptr_alt] <= data.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cst_pkg::QPTR_W'(n_in);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

@@ rtl/cst_checker.sv @@
// ----------------------------------------------------------------------------
// cst_checker: port-level checks for the tokenizer
// Watches the top level's ports for handshake and token shape rules.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     char_in,
  input logic                           end_of_input,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cst_pkg::KIND_W-1:0]     token_kind,
  input logic [cst_pkg::START_W-1:0]    token_start,
  input logic [cst_pkg::LENGTH_W-1:0]   token_length,
  input logic                           last_of_run
);

  // a stalled input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(char_in) && $stable(end_of_input))
    else $error("input item changed while stalled");

  // a stalled item stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) &&
      $stable(token_start) && $stable(token_length) && $stable(last_of_run))
    else $error("output item changed while stalled");

  // every token has at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_length != '0)
    else $error("zero-length token");

  // single characters are one byte long
  a_other_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == 3'(cst_pkg::KIND_OTHER) |-> token_length == 12'd1)
    else $error("single-character token with wrong length");

  // relational operators are one or two bytes
  a_rel_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == 3'(cst_pkg::KIND_REL) |->
      token_length == 12'd1 || token_length == 12'd2)
    else $error("relational operator with wrong length");

endmodule

bind character_stream_tokenizer_top cst_checker u_cst_checker (.*);
